// ===== hw/rtl/hbmm_pkg.sv =====
// Shared types and constants for the handheld bus memory map unit.
package hbmm_pkg;

   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_LOAD   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] SEL_NONE    = 2'd0;
   localparam logic [1:0] SEL_JOYPAD  = 2'd1;
   localparam logic [1:0] SEL_DIVIDER = 2'd2;
   localparam logic [1:0] SEL_DISPLAY = 2'd3;

   localparam logic [15:0] ADDR_JOYPAD  = 16'hFF00;
   localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
   localparam logic [15:0] ADDR_DMA     = 16'hFF46;
   localparam logic [7:0]  JOYPAD_MASK  = 8'h30;
   localparam logic [7:0]  DMA_LENGTH   = 8'd160;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [7:0]  value;
      logic [7:0]  ext_read_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] periph_select;
      logic [7:0] periph_reg;
      logic       periph_write;
      logic [7:0] periph_data;
      logic       access_error;
   } rsp_type;

   // Memory regions.
   typedef enum logic [3:0] {
      RG_ROM, RG_VRAM, RG_XRAM, RG_WRAM, RG_OAM, RG_BAD, RG_IO, RG_HRAM, RG_IE
   } region_type;

   typedef struct packed {
      region_type region;
      logic [12:0] offset;
   } decode_type;

   function automatic decode_type decode(input logic [15:0] a);
      decode_type d;
      logic [7:0] h;
      d.region = RG_ROM;
      d.offset = a[12:0];
      h = a[7:0] - 8'h80;
      if (a <= 16'h7FFF) begin
         d.region = RG_ROM;
      end else if (a <= 16'h9FFF) begin
         d.region = RG_VRAM;
      end else if (a <= 16'hBFFF) begin
         d.region = RG_XRAM;
      end else if (a <= 16'hFDFF) begin
         d.region = RG_WRAM;
      end else if (a <= 16'hFE9F) begin
         d.region = RG_OAM;
         d.offset = {5'd0, a[7:0]};
      end else if (a <= 16'hFEFF) begin
         d.region = RG_BAD;
      end else if (a <= 16'hFF7F) begin
         d.region = RG_IO;
         d.offset = {6'd0, a[6:0]};
      end else if (a <= 16'hFFFE) begin
         d.region = RG_HRAM;
         d.offset = {6'd0, h[6:0]};
      end else begin
         d.region = RG_IE;
      end
      return d;
   endfunction

   function automatic logic [1:0] periph_of(input logic [15:0] a);
      logic [1:0] s;
      s = SEL_NONE;
      if (a == ADDR_JOYPAD) s = SEL_JOYPAD;
      else if (a == ADDR_DIVIDER) s = SEL_DIVIDER;
      else if (a[15:3] == 13'h1FE8) s = SEL_DISPLAY;
      return s;
   endfunction

endpackage

// ===== hw/rtl/handheld_bus_memory_map_unit.sv =====
// Top level of the handheld bus memory map unit with its OAM DMA sequencer.
//
// Usage: one bus access per req_ beat (read, write or ROM load); one rsp_
// beat per access. Memories are block RAMs with registered reads.
// After reset a clearing pass walks all memories, one address per cycle
// (the ROM depth sets the length); no request is taken meanwhile.
// A memory read passes through ST_READ (RAM read) and ST_DWAIT (result)
// before rsp_valid comes up, a plain memory write through ST_OUT (write),
// while routed accesses, ROM loads and unused commands skip those states.
// A write to 0xFF46 also runs the DMA: 160 bytes, each one read (ST_DRD)
// then one write (ST_DWR) through the shared memory port; the response
// comes up once the last byte is written.
// One access at a time: req_ready is high only while the sequencer is idle
// and the output register is empty. A stalled receiver holds the response
// in the output register; the next request waits until it is taken.
module handheld_bus_memory_map_unit
   import hbmm_pkg::*;
#(
   parameter int ROM_BYTES = 32768
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int RW = $clog2(ROM_BYTES);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_DRD   = 7'b0001000,
      ST_DWR   = 7'b0010000,
      ST_DWAIT = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [RW-1:0] clr_ff, clr_in;
   logic [7:0] dma_ff, dma_in;
   logic [7:0] page_ff, page_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;
   logic rd_bad_ff, rd_bad_in;
   decode_type rdec_ff, rdec_in;

   logic [7:0] rom_mem [ROM_BYTES];
   logic [7:0] vram_mem [8192];
   logic [7:0] xram_mem [8192];
   logic [7:0] wram_mem [8192];
   logic [7:0] oam_mem [160];
   logic [7:0] io_mem [128];
   logic [7:0] hram_mem [128];
   logic [7:0] ie_ff;

   logic [7:0] rom_q, vram_q, xram_q, wram_q, oam_q, io_q, hram_q;

   // shared memory port: one address, one read or write per cycle
   logic [15:0] m_addr;
   logic        m_we;
   logic [7:0]  m_wd;
   decode_type  m_dec;
   logic        ld_we;
   logic        clr_on;
   logic [7:0]  m_rd;
   logic [15:0] dsrc;

   assign dsrc  = {page_ff, 8'h00} + {8'h00, dma_ff};
   assign clr_on = (state_ff == ST_CLEAR);

   always_comb begin
      m_addr = req_ff.address;
      m_we = 1'b0;
      m_wd = req_ff.value;
      // plain write in ST_OUT goes through the shared port
      if (state_ff == ST_OUT) m_we = 1'b1;
      if (state_ff == ST_DRD) m_addr = dsrc;
      if (state_ff == ST_DWR) begin
         m_addr = 16'hFE00 + {8'h00, dma_ff};
         m_we = 1'b1;
         m_wd = m_rd;
      end
   end
   assign m_dec = decode(m_addr);
   assign ld_we = (state_ff == ST_IDLE) && req_valid && !rspv_ff &&
                  (req_data.command == CMD_LOAD) &&
                  ({16'h0, req_data.address} < 32'(ROM_BYTES));

   // memory arrays, clocked read and write
   always_ff @(posedge clock) begin
      if (clr_on) begin
         rom_mem[clr_ff] <= 8'h00;
         vram_mem[clr_ff[12:0]] <= 8'h00;
         xram_mem[clr_ff[12:0]] <= 8'h00;
         wram_mem[clr_ff[12:0]] <= 8'h00;
         if (clr_ff < RW'(160)) oam_mem[clr_ff[7:0]] <= 8'h00;
         io_mem[clr_ff[6:0]] <= 8'h00;
         hram_mem[clr_ff[6:0]] <= 8'h00;
      end else begin
         if (ld_we) rom_mem[req_data.address[RW-1:0]] <= req_data.value;
         if (m_we) begin
            case (m_dec.region)
               RG_VRAM: vram_mem[m_dec.offset] <= m_wd;
               RG_XRAM: xram_mem[m_dec.offset] <= m_wd;
               RG_WRAM: wram_mem[m_dec.offset] <= m_wd;
               RG_OAM:  oam_mem[m_dec.offset[7:0]] <= m_wd;
               RG_IO:   io_mem[m_dec.offset[6:0]] <= m_wd;
               RG_HRAM: hram_mem[m_dec.offset[6:0]] <= m_wd;
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req_valid && !rspv_ff &&
             req_data.command == CMD_WRITE &&
             periph_of(req_data.address) == SEL_DISPLAY)
            io_mem[req_data.address[6:0]] <= req_data.value;
      end
      rom_q  <= rom_mem[m_addr[RW-1:0]];
      vram_q <= vram_mem[m_dec.offset];
      xram_q <= xram_mem[m_dec.offset];
      wram_q <= wram_mem[m_dec.offset];
      oam_q  <= oam_mem[m_dec.offset[7:0]];
      io_q   <= io_mem[m_dec.offset[6:0]];
      hram_q <= hram_mem[m_dec.offset[6:0]];
   end

   // interrupt enable byte
   always_ff @(posedge clock) begin
      if (reset) begin
         ie_ff <= 8'h00;
      end else if (m_we && m_dec.region == RG_IE) begin
         ie_ff <= m_wd;
      end
   end

   // read mux on registered RAM data
   always_comb begin
      case (rdec_ff.region)
         RG_ROM:  m_rd = rd_bad_ff ? 8'hFF : rom_q;
         RG_VRAM: m_rd = vram_q;
         RG_XRAM: m_rd = xram_q;
         RG_WRAM: m_rd = wram_q;
         RG_OAM:  m_rd = (rdec_ff.offset < 13'd160) ? oam_q : 8'hFF;
         RG_IO:   m_rd = io_q;
         RG_HRAM: m_rd = hram_q;
         RG_IE:   m_rd = ie_ff;
         default: m_rd = 8'hFF;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      logic [1:0] sel;
      state_in = state_ff;
      clr_in = clr_ff;
      dma_in = dma_ff;
      page_in = page_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rspv_in = rspv_ff;
      rdec_in = m_dec;
      rd_bad_in = ({16'h0, m_addr} >= 32'(ROM_BYTES));
      sel = periph_of(req_data.address);
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + RW'(1);
            if (clr_ff == RW'(ROM_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && !rspv_ff) begin
               req_in = req_data;
               rsp_in = '0;
               case (req_data.command)
                  CMD_READ: begin
                     if (req_data.address == ADDR_DMA) sel = SEL_NONE;
                     if (sel != SEL_NONE) begin
                        rsp_in.read_data = req_data.ext_read_data;
                        rsp_in.periph_select = sel;
                        rsp_in.periph_reg = req_data.address[7:0];
                        rspv_in = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  CMD_WRITE: begin
                     if (sel != SEL_NONE) begin
                        rsp_in.periph_select = sel;
                        rsp_in.periph_reg = req_data.address[7:0];
                        rsp_in.periph_write = 1'b1;
                        rsp_in.periph_data = (sel == SEL_JOYPAD) ?
                           (req_data.value & JOYPAD_MASK) : req_data.value;
                     end
                     if (req_data.address == ADDR_DMA) begin
                        page_in = req_data.value;
                        dma_in = 8'd0;
                        state_in = ST_DRD;
                     end else if (sel == SEL_NONE) begin
                        state_in = ST_OUT;
                     end else begin
                        rspv_in = 1'b1;
                     end
                  end
                  default: rspv_in = 1'b1;
               endcase
            end
         end
         ST_READ: state_in = ST_DWAIT;
         ST_DWAIT: begin
            rsp_in.read_data = m_rd;
            rsp_in.access_error = (rdec_ff.region == RG_BAD);
            rspv_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_OUT: begin
            // plain memory write happens in this cycle
            rspv_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DRD: begin
            state_in = ST_DWR;
            rdec_in = m_dec;
         end
         ST_DWR: begin
            rdec_in = rdec_ff;
            dma_in = dma_ff + 8'd1;
            if (dma_ff == DMA_LENGTH - 8'd1) begin
               rspv_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rspv_ff <= rspv_in;
      end
      dma_ff <= dma_in;
      page_ff <= page_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      rdec_ff <= rdec_in;
      rd_bad_ff <= rd_bad_in;
   end

   // assertions
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rspv_ff && !rsp_ready) |=> $stable(rsp_ff)) else $error("rsp changed");
   a_dma: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DWR) |-> (dma_ff < DMA_LENGTH)) else $error("dma overrun");

endmodule

// ===== bench/handheld_bus_memory_map_unit_test.sv =====
// Testbench for the handheld bus memory map unit: directed table, then random bus traffic.
module handheld_bus_memory_map_unit_test
   import hbmm_pkg::*;
();

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   handheld_bus_memory_map_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted memory contents
   logic [7:0] rom_mem [32768];
   logic [7:0] vram_mem [8192];
   logic [7:0] xram_mem [8192];
   logic [7:0] wram_mem [8192];
   logic [7:0] oam_mem [160];
   logic [7:0] io_mem [128];
   logic [7:0] hram_mem [127];
   logic [7:0] ie_reg;

   rsp_type expected_rsps [$];
   int      failures = 0;
   bit      calm = 1'b0;
   bit      stim_done = 1'b0;

   function automatic logic [7:0] bus_peek(input logic [15:0] a, output bit err);
      err = 1'b0;
      if (a <= 16'h7FFF) return rom_mem[a[14:0]];
      if (a <= 16'h9FFF) return vram_mem[a[12:0]];
      if (a <= 16'hBFFF) return xram_mem[a[12:0]];
      if (a <= 16'hDFFF) return wram_mem[a[12:0]];
      if (a <= 16'hFDFF) return wram_mem[a[12:0]];
      if (a <= 16'hFE9F) return oam_mem[a[7:0]];
      if (a <= 16'hFEFF) begin
         err = 1'b1;
         return 8'hFF;
      end
      if (a <= 16'hFF7F) return io_mem[a[6:0]];
      if (a <= 16'hFFFE) return hram_mem[a[6:0]];
      return ie_reg;
   endfunction

   function automatic void bus_poke(input logic [15:0] a, input logic [7:0] v);
      if (a <= 16'h7FFF) return;
      else if (a <= 16'h9FFF) vram_mem[a[12:0]] = v;
      else if (a <= 16'hBFFF) xram_mem[a[12:0]] = v;
      else if (a <= 16'hDFFF) wram_mem[a[12:0]] = v;
      else if (a <= 16'hFDFF) wram_mem[a[12:0]] = v;
      else if (a <= 16'hFE9F) oam_mem[a[7:0]] = v;
      else if (a <= 16'hFEFF) return;
      else if (a <= 16'hFF7F) io_mem[a[6:0]] = v;
      else if (a <= 16'hFFFE) hram_mem[a[6:0]] = v;
      else ie_reg = v;
   endfunction

   function automatic logic [1:0] route_of(input logic [15:0] a);
      if (a == ADDR_JOYPAD) return SEL_JOYPAD;
      if (a == ADDR_DIVIDER) return SEL_DIVIDER;
      if (a >= 16'hFF40 && a <= 16'hFF47) return SEL_DISPLAY;
      return SEL_NONE;
   endfunction

   // Apply one access to the predicted map and return the predicted response
   function automatic rsp_type bus_access(input req_type r);
      rsp_type o;
      bit e;
      logic [7:0] b;
      o = '0;
      if (r.command == CMD_READ) begin
         o.periph_select = route_of(r.address);
         if (r.address == ADDR_DMA) o.periph_select = SEL_NONE;
         if (o.periph_select != SEL_NONE) o.read_data = r.ext_read_data;
         else begin
            o.read_data = bus_peek(r.address, e);
            o.access_error = e;
         end
      end else if (r.command == CMD_WRITE) begin
         o.periph_select = route_of(r.address);
         if (o.periph_select != SEL_NONE) begin
            o.periph_write = 1'b1;
            o.periph_data = (o.periph_select == SEL_JOYPAD) ?
                            (r.value & JOYPAD_MASK) : r.value;
         end
         if (o.periph_select == SEL_DISPLAY) begin
            io_mem[r.address[6:0]] = r.value;
            if (r.address == ADDR_DMA)
               for (int i = 0; i < 160; i++) begin
                  b = bus_peek({r.value, 8'h00} + 16'(i), e);
                  bus_poke(16'hFE00 + 16'(i), b);
               end
         end else if (o.periph_select == SEL_NONE) bus_poke(r.address, r.value);
      end else if (r.command == CMD_LOAD) begin
         if (r.address < 16'h8000) rom_mem[r.address[14:0]] = r.value;
      end
      if (o.periph_select != SEL_NONE) o.periph_reg = r.address[7:0];
      return o;
   endfunction

   // One request beat; waits for acceptance
   task automatic send_beat(input req_type r);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(bus_access(r));
   endtask

   function automatic req_type mk(input logic [1:0] c, input logic [15:0] a,
                                  input logic [7:0] v, input logic [7:0] x);
      req_type r;
      r.command = c; r.address = a; r.value = v; r.ext_read_data = x;
      return r;
   endfunction

   // Random address biased toward interesting regions
   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 9))
         0: return 16'($urandom_range(16'h0000, 16'h7FFF));
         1: return 16'($urandom_range(16'h8000, 16'h801F));
         2: return 16'($urandom_range(16'hA000, 16'hBFFF));
         3: return 16'($urandom_range(16'hC000, 16'hC01F));
         4: return 16'($urandom_range(16'hE000, 16'hE01F));
         5: return 16'($urandom_range(16'hFE00, 16'hFEFF));
         6: return 16'($urandom_range(16'hFF00, 16'hFF7F));
         7: return 16'($urandom_range(16'hFF80, 16'hFFFF));
         8: return 16'($urandom_range(16'hFF40, 16'hFF47));
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   typedef struct {
      req_type stim;
      bit      known;
      rsp_type want;
   } row_type;

   row_type rows [$];

   initial begin
      req_type r;
      rsp_type w;
      int n;
      foreach (rom_mem[i]) rom_mem[i] = '0;
      foreach (vram_mem[i]) vram_mem[i] = '0;
      foreach (xram_mem[i]) xram_mem[i] = '0;
      foreach (wram_mem[i]) wram_mem[i] = '0;
      foreach (oam_mem[i]) oam_mem[i] = '0;
      foreach (io_mem[i]) io_mem[i] = '0;
      foreach (hram_mem[i]) hram_mem[i] = '0;
      ie_reg = '0;

      // Directed table; want is filled only where obvious
      rows.push_back('{mk(CMD_READ, 16'h0000, 8'h00, 8'hFF), 1, '0});
      rows.push_back('{mk(CMD_READ, 16'hFEA0, 8'h00, 8'h00), 1,
                       '{8'hFF, SEL_NONE, 8'h00, 1'b0, 8'h00, 1'b1}});
      rows.push_back('{mk(CMD_READ, 16'hFEFF, 8'hFF, 8'hFF), 1,
                       '{8'hFF, SEL_NONE, 8'h00, 1'b0, 8'h00, 1'b1}});
      rows.push_back('{mk(CMD_WRITE, ADDR_JOYPAD, 8'hFF, 8'h00), 1,
                       '{8'h00, SEL_JOYPAD, 8'h00, 1'b1, 8'h30, 1'b0}});
      rows.push_back('{mk(CMD_READ, ADDR_JOYPAD, 8'h00, 8'hA5), 1,
                       '{8'hA5, SEL_JOYPAD, 8'h00, 1'b0, 8'h00, 1'b0}});
      rows.push_back('{mk(CMD_WRITE, ADDR_DIVIDER, 8'h5A, 8'h00), 1,
                       '{8'h00, SEL_DIVIDER, 8'h04, 1'b1, 8'h5A, 1'b0}});
      rows.push_back('{mk(CMD_READ, ADDR_DIVIDER, 8'h00, 8'h3C), 1,
                       '{8'h3C, SEL_DIVIDER, 8'h04, 1'b0, 8'h00, 1'b0}});
      rows.push_back('{mk(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF), 1, '0});
      rows.push_back('{mk(CMD_LOAD, 16'h7FFF, 8'hAB, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_LOAD, 16'h8000, 8'hCD, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_LOAD, 16'h0000, 8'h11, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_READ, 16'h7FFF, 8'h00, 8'h00), 0, '0});
      rows.push_back('{mk(CMD_WRITE, 16'h0000, 8'h99, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_READ, 16'h0000, 8'h00, 8'h00), 0, '0});
      rows.push_back('{mk(CMD_WRITE, 16'hC000, 8'h77, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_READ, 16'hE000, 8'h00, 8'h00), 0, '0});
      rows.push_back('{mk(CMD_WRITE, 16'hFDFF, 8'h42, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_WRITE, 16'hFFFF, 8'hFF, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_WRITE, 16'hFFFE, 8'h01, 8'h00), 1, '0});
      rows.push_back('{mk(CMD_READ, 16'hFFFF, 8'h00, 8'h00), 0, '0});
      rows.push_back('{mk(CMD_WRITE, 16'hFF40, 8'h91, 8'h00), 1,
                       '{8'h00, SEL_DISPLAY, 8'h40, 1'b1, 8'h91, 1'b0}});
      rows.push_back('{mk(CMD_WRITE, ADDR_DMA, 8'hC0, 8'h00), 0, '0});
      rows.push_back('{mk(CMD_READ, ADDR_DMA, 8'h00, 8'h55), 0, '0});
      rows.push_back('{mk(CMD_READ, 16'hFE00, 8'h00, 8'h00), 0, '0});
      rows.push_back('{mk(CMD_WRITE, ADDR_DMA, 8'hFF, 8'h00), 0, '0});
      rows.push_back('{mk(CMD_READ, 16'hFE9F, 8'h00, 8'h00), 0, '0});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         w = bus_access(rows[i].stim);
         if (rows[i].known && w !== rows[i].want) begin
            $display("%0t: table row %0d want %h model %h", $time, i, rows[i].want, w);
            failures++;
         end
         // the prediction is undone after the loop; send_beat redoes it on acceptance
      end
      // Restore predicted state by replaying from reset
      foreach (rom_mem[i]) rom_mem[i] = '0;
      foreach (vram_mem[i]) vram_mem[i] = '0;
      foreach (xram_mem[i]) xram_mem[i] = '0;
      foreach (wram_mem[i]) wram_mem[i] = '0;
      foreach (oam_mem[i]) oam_mem[i] = '0;
      foreach (io_mem[i]) io_mem[i] = '0;
      foreach (hram_mem[i]) hram_mem[i] = '0;
      ie_reg = '0;
      foreach (rows[i]) send_beat(rows[i].stim);

      // Random traffic; DMA writes are kept rare
      for (n = 0; n < 1600; n++) begin
         if (n > 1400) calm = 1'b1;
         r.address = pick_addr();
         r.value = 8'($urandom);
         r.ext_read_data = 8'($urandom);
         case ($urandom_range(0, 19))
            0: r.command = CMD_UNUSED;
            1, 2, 3: r.command = CMD_LOAD;
            4, 5, 6, 7, 8, 9, 10: r.command = CMD_WRITE;
            default: r.command = CMD_READ;
         endcase
         if (r.command == CMD_WRITE && r.address == ADDR_DMA && $urandom_range(0, 1))
            r.address = 16'hFF47;
         if ($urandom_range(0, 60) == 0) begin
            r.command = CMD_WRITE;
            r.address = ADDR_DMA;
         end
         send_beat(r);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver with bursty stalls
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            failures++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.read_data !== want.read_data) begin
               $display("%0t: read_data exp %h got %h", $time, want.read_data,
                        rsp_data.read_data);
               failures++;
            end
            if (rsp_data.periph_select !== want.periph_select) begin
               $display("%0t: periph_select exp %h got %h", $time, want.periph_select,
                        rsp_data.periph_select);
               failures++;
            end
            if (rsp_data.periph_reg !== want.periph_reg) begin
               $display("%0t: periph_reg exp %h got %h", $time, want.periph_reg,
                        rsp_data.periph_reg);
               failures++;
            end
            if (rsp_data.periph_write !== want.periph_write) begin
               $display("%0t: periph_write exp %h got %h", $time, want.periph_write,
                        rsp_data.periph_write);
               failures++;
            end
            if (rsp_data.periph_data !== want.periph_data) begin
               $display("%0t: periph_data exp %h got %h", $time, want.periph_data,
                        rsp_data.periph_data);
               failures++;
            end
            if (rsp_data.access_error !== want.access_error) begin
               $display("%0t: access_error exp %h got %h", $time, want.access_error,
                        rsp_data.access_error);
               failures++;
            end
         end
      end
   end

   // Drain and report
   initial begin
      wait (stim_done);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (failures == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #8000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
